>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked at every rising clock edge outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/sabs_pkg.sv
// shared constants, command codes and controller/datapath interface types
package sabs_pkg;

   // default array depth
   localparam int ARRAY_DEPTH_DEFAULT = 1024;

   // fixed field widths
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 10;
   localparam int LENGTH_W = 11;

   // item command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic write;    // store one entry
      logic start;    // load key and full search range
      logic step;     // apply one probe result
      logic publish;  // move the result into the output register
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic start_empty;  // search range is empty from the outset
      logic hit;          // probed entry equals the key
      logic next_empty;   // range after this probe is empty
   } dp_status_type;

endpackage

>>> hw/rtl/sabs_ram.sv
// generic simple dual-port ram with registered read
module sabs_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/sabs_dp.sv
// search datapath: length register, array memory, range bounds and compare
module sabs_dp #(
   parameter int ARRAY_DEPTH = sabs_pkg::ARRAY_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [sabs_pkg::LENGTH_W-1:0]        csr_write_data,
   input  logic [sabs_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic signed [sabs_pkg::VALUE_W-1:0]  req_entry_value,
   input  logic signed [sabs_pkg::VALUE_W-1:0]  req_search_key,
   input  sabs_pkg::dp_cmd_type                 cmd,
   output sabs_pkg::dp_status_type              status,
   output logic                                 rsp_found
);

   localparam int AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
   localparam int LW = $clog2(ARRAY_DEPTH + 1);

   logic [sabs_pkg::LENGTH_W-1:0]       length_ff;
   logic [LW-1:0]                       eff_len;
   logic [LW-1:0]                       low_ff, low_in, low_step;
   logic [LW-1:0]                       high_ff, high_in, high_step;
   logic [LW-1:0]                       mid_wide;
   logic [LW:0]                         mid_sum;
   logic [AW-1:0]                       mid_ff, mid_in;
   logic signed [sabs_pkg::VALUE_W-1:0] key_ff;
   logic signed [sabs_pkg::VALUE_W-1:0] probe;
   logic [sabs_pkg::VALUE_W-1:0]        rd_data;
   logic                                found_ff;
   logic                                rsp_found_ff;
   logic                                wr_en;
   logic [AW-1:0]                       wr_addr;
   logic                                hit;
   logic                                below;

   // length register
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else if (csr_write_enable) begin
         length_ff <= csr_write_data;
      end
   end

   // length saturated to the array depth
   always_comb begin
      if (int'(length_ff) > ARRAY_DEPTH) begin
         eff_len = LW'(ARRAY_DEPTH);
      end else begin
         eff_len = LW'(length_ff);
      end
   end

   // entry writes beyond the depth are dropped
   assign wr_en   = cmd.write && (int'(req_entry_index) < ARRAY_DEPTH);
   assign wr_addr = AW'(req_entry_index);

   // array storage
   sabs_ram #(
      .WIDTH  (sabs_pkg::VALUE_W),
      .DEPTH  (ARRAY_DEPTH),
      .ADDR_W (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_entry_value),
      .rd_addr (mid_in),
      .rd_data (rd_data)
   );

   // probe compare and range narrowing, half-open range [low, high)
   always_comb begin
      probe    = $signed(rd_data);
      hit      = (probe == key_ff);
      below    = (probe < key_ff);
      mid_wide = LW'(mid_ff);
      if (below) begin
         low_step  = mid_wide + LW'(1);
         high_step = high_ff;
      end else begin
         low_step  = low_ff;
         high_step = mid_wide;
      end
      if (cmd.start) begin
         low_in  = '0;
         high_in = eff_len;
      end else begin
         low_in  = low_step;
         high_in = high_step;
      end
      // floor of the midpoint of the inclusive range [low, high - 1]
      mid_sum = {1'b0, low_in} + {1'b0, high_in} - (LW + 1)'(1);
      mid_in  = mid_sum[AW:1];
   end

   assign status.start_empty = (eff_len == '0);
   assign status.hit         = hit;
   assign status.next_empty  = (low_step >= high_step);

   // search registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff   <= req_search_key;
         found_ff <= 1'b0;
      end else if (cmd.step) begin
         found_ff <= hit;
      end
      if (cmd.start || cmd.step) begin
         low_ff  <= low_in;
         high_ff <= high_in;
         mid_ff  <= mid_in;
      end
      if (cmd.publish) begin
         rsp_found_ff <= found_ff;
      end
   end

   assign rsp_found = rsp_found_ff;

endmodule

>>> hw/rtl/sabs_ctrl.sv
// search controller: handshakes and probe sequencing
`include "assert_macros.svh"

module sabs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_command,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  sabs_pkg::dp_status_type status,
   output sabs_pkg::dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // input handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // datapath commands
   always_comb begin
      cmd.write   = accept && (req_command == sabs_pkg::CMD_WRITE);
      cmd.start   = accept && (req_command == sabs_pkg::CMD_SEARCH);
      cmd.step    = (state_ff == ST_PROBE);
      cmd.publish = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = status.start_empty ? ST_FINISH : ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (status.hit || status.next_empty) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (cmd.publish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output valid
   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // an empty range skips probing
   `ASSERT_NEXT(a_empty_skips, clock, reset, cmd.start && status.start_empty, state_ff == ST_FINISH)
   // a hit ends the probe loop
   `ASSERT_NEXT(a_hit_ends, clock, reset, cmd.step && status.hit, state_ff == ST_FINISH)
   // a published result is shown in the next cycle
   `ASSERT_NEXT(a_publish_shows, clock, reset, cmd.publish, rsp_valid_ff)
   // no new item is taken while a search is running
   `ASSERT_IMPLIES(a_no_overlap, clock, reset, cmd.step, !cmd.start && !cmd.write)

endmodule

>>> hw/rtl/sorted_array_binary_search_unit.sv
// Binary search over a sorted array of signed 32-bit entries.
// A write item leaves the unit idle, so the next item can be accepted in the following cycle.
// A search item makes at most ceil(log2(n + 1)) probes, n being the length saturated to ARRAY_DEPTH,
// one per cycle (one memory read each); the next item is accepted only after the result is
// published, which waits while a previous result is still held valid under a stalled output.
// Synchronous reset clears the length and the control state; array contents stay undefined.
module sorted_array_binary_search_unit #(
   parameter int ARRAY_DEPTH = sabs_pkg::ARRAY_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [sabs_pkg::LENGTH_W-1:0]       csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [sabs_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic signed [sabs_pkg::VALUE_W-1:0] req_entry_value,
   input  logic signed [sabs_pkg::VALUE_W-1:0] req_search_key,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found
);

   sabs_pkg::dp_cmd_type    cmd;
   sabs_pkg::dp_status_type status;

   // controller
   sabs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // datapath
   sabs_dp #(
      .ARRAY_DEPTH (ARRAY_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .req_search_key   (req_search_key),
      .cmd              (cmd),
      .status           (status),
      .rsp_found        (rsp_found)
   );

endmodule
